[src/assert_macros.svh]
// Assertion shorthands for the Trivium keystream cipher checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TKC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TKC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkc: next-cycle check failed");

`endif

[src/tkc_pkg.sv]
// Shared constants, types and functions of the Trivium keystream cipher.
// Used by the controller, the datapath, the top level and the checker.
package tkc_pkg;

    localparam int WORD_BITS    = 64;
    localparam int STATE_BITS   = 288;
    localparam int WARMUP_STEPS = 4 * STATE_BITS;
    localparam int COUNT_W      = $clog2(WORD_BITS + 1);
    localparam int REM_W        = $clog2(WARMUP_STEPS + 1);
    localparam int LG_MAX       = $clog2(WORD_BITS + 1) - 1;
    localparam int LG_LEVELS    = LG_MAX + 1;
    localparam int LG_W         = (LG_MAX > 0) ? $clog2(LG_MAX + 1) : 1;

    localparam int KEY_BITS   = 80;
    localparam int LOW_W      = 64;
    localparam int HIGH_W     = KEY_BITS - LOW_W;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int IV_POS     = 93;

    // Register boundaries and taps of the three shift registers.
    localparam int A_LAST = 92;
    localparam int B_FIRST = 93;
    localparam int B_LAST = 176;
    localparam int C_FIRST = 177;
    localparam int TAP_A_OUT = 65;
    localparam int TAP_A_FB  = 68;
    localparam int TAP_A_AND = 90;
    localparam int TAP_B_OUT = 161;
    localparam int TAP_B_FB  = 170;
    localparam int TAP_B_AND = 174;
    localparam int TAP_C_OUT = 242;
    localparam int TAP_C_FB  = 263;
    localparam int TAP_C_AND = 285;
    localparam int TAP_C_END = 287;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = 2'd3;

    localparam logic MODE_RESTART = 1'b0;
    localparam logic MODE_DATA    = 1'b1;

    typedef struct packed {
        logic [STATE_BITS-1:0] state;
        logic [WORD_BITS-1:0]  ks;
    } adv_t;

    typedef struct packed {
        logic               load_key;
        logic               load_data;
        logic               step;
        logic [LG_W-1:0]    lg;
        logic [COUNT_W-1:0] offset;
        logic               load_out;
    } cmd_t;

    // Advances the state by k steps at once. No tap reads a bit written within
    // the last 65 steps, so all k steps are computed from the current state.
    function automatic adv_t tkc_advance(input logic [STATE_BITS-1:0] s, input int k);
        adv_t r;
        logic t1;
        logic t2;
        logic t3;
        logic [WORD_BITS-1:0] na;
        logic [WORD_BITS-1:0] nb;
        logic [WORD_BITS-1:0] nc;
        r  = '0;
        na = '0;
        nb = '0;
        nc = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (j < k) begin
                t1 = s[TAP_A_OUT - j] ^ s[A_LAST - j];
                t2 = s[TAP_B_OUT - j] ^ s[B_LAST - j];
                t3 = s[TAP_C_OUT - j] ^ s[TAP_C_END - j];
                r.ks[j] = t1 ^ t2 ^ t3;
                na[j] = t1 ^ (s[TAP_A_AND - j] & s[TAP_A_AND + 1 - j]) ^ s[TAP_B_FB - j];
                nb[j] = t2 ^ (s[TAP_B_AND - j] & s[TAP_B_AND + 1 - j]) ^ s[TAP_C_FB - j];
                nc[j] = t3 ^ (s[TAP_C_AND - j] & s[TAP_C_AND + 1 - j]) ^ s[TAP_A_FB - j];
            end
        end
        for (int i = 0; i <= A_LAST; i++) begin
            if (i < k) r.state[i] = nc[k - 1 - i];
            else       r.state[i] = s[i - k];
        end
        for (int i = 0; i <= B_LAST - B_FIRST; i++) begin
            if (i < k) r.state[B_FIRST + i] = na[k - 1 - i];
            else       r.state[B_FIRST + i] = s[B_FIRST + i - k];
        end
        for (int i = 0; i <= TAP_C_END - C_FIRST; i++) begin
            if (i < k) r.state[C_FIRST + i] = nb[k - 1 - i];
            else       r.state[C_FIRST + i] = s[C_FIRST + i - k];
        end
        return r;
    endfunction

    // Counts above the word width are clamped to the word width.
    function automatic logic [COUNT_W-1:0] tkc_sat_count(input logic [COUNT_W-1:0] c);
        if (c > COUNT_W'(WORD_BITS)) return COUNT_W'(WORD_BITS);
        return c;
    endfunction

    // Largest power-of-two step that does not overshoot the remaining steps.
    function automatic logic [LG_W-1:0] tkc_step_lg(input logic [REM_W-1:0] rem);
        logic [LG_W-1:0] lg;
        lg = '0;
        for (int g = 1; g < LG_LEVELS; g++) begin
            if (rem >= REM_W'(1 << g)) lg = LG_W'(g);
        end
        return lg;
    endfunction

    function automatic logic [WORD_BITS-1:0] tkc_low_mask(input int k);
        logic [WORD_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (i < k) m[i] = 1'b1;
        end
        return m;
    endfunction

endpackage

[src/tkc_ctrl.sv]
// Controller of the Trivium keystream cipher: item sequencing and output handshake.
// Depends on tkc_pkg; drives the datapath through cmd_t.
module tkc_ctrl
    import tkc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic [COUNT_W-1:0] bit_count,
    output logic               out_valid,
    input  logic               out_stall,
    output cmd_t               cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_STEP = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0] done_reg, done_next;
    logic               is_data_reg, is_data_next;
    logic               out_valid_reg, out_valid_next;
    logic [LG_W-1:0]    lg;

    assign lg        = tkc_step_lg(rem_reg);
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        done_next      = done_reg;
        is_data_next   = is_data_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.lg         = lg;
        cmd.offset     = done_reg;

        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    state_next = ST_STEP;
                    done_next  = '0;
                    if (mode == MODE_RESTART) begin
                        cmd.load_key = 1'b1;
                        rem_next     = REM_W'(WARMUP_STEPS);
                        is_data_next = 1'b0;
                    end
                    else begin
                        cmd.load_data = 1'b1;
                        rem_next      = REM_W'(tkc_sat_count(bit_count));
                        is_data_next  = 1'b1;
                    end
                end
            end
            ST_STEP:
            begin
                if (rem_reg != '0) begin
                    cmd.step  = 1'b1;
                    rem_next  = rem_reg - (REM_W'(1) << lg);
                    done_next = done_reg + (COUNT_W'(1) << lg);
                end
                else if (is_data_reg) begin
                    state_next = ST_EMIT;
                end
                else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                // The output register must be empty or drained in this cycle.
                if (!out_valid_reg || !out_stall) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            rem_reg       <= '0;
            done_reg      <= '0;
            is_data_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            done_reg      <= done_next;
            is_data_reg   <= is_data_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/tkc_datapath.sv]
// Datapath of the Trivium keystream cipher: key and IV registers, cipher state,
// power-of-two step unit and result registers. Depends on tkc_pkg.
module tkc_datapath
    import tkc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [WORD_BITS-1:0]  data_word,
    input  logic [COUNT_W-1:0]    bit_count,
    input  cmd_t                  cmd,
    output logic [WORD_BITS-1:0]  result_word,
    output logic [COUNT_W-1:0]    result_count
);

    logic [LOW_W-1:0]      key_low_reg, iv_low_reg;
    logic [HIGH_W-1:0]     key_high_reg, iv_high_reg;
    logic [STATE_BITS-1:0] state_reg, state_next;
    logic [STATE_BITS-1:0] init_state;
    logic [WORD_BITS-1:0]  data_reg, data_next;
    logic [WORD_BITS-1:0]  res_reg, res_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [WORD_BITS-1:0]  result_word_reg;
    logic [COUNT_W-1:0]    result_count_reg;

    adv_t                  cand [LG_LEVELS];
    adv_t                  sel;
    logic [WORD_BITS-1:0]  sel_mask;
    logic [WORD_BITS-1:0]  sel_shifted;
    logic [WORD_BITS-1:0]  chunk;

    for (genvar g = 0; g < LG_LEVELS; g++) begin : g_step
        assign cand[g] = tkc_advance(state_reg, 1 << g);
    end

    always_comb
    begin
        init_state = '0;
        init_state[KEY_BITS-1:0] = {key_high_reg, key_low_reg};
        init_state[IV_POS +: KEY_BITS] = {iv_high_reg, iv_low_reg};
        init_state[TAP_C_END:TAP_C_AND] = '1;
    end

    // Pick the candidate for the chosen step size.
    always_comb
    begin
        sel         = cand[0];
        sel_mask    = tkc_low_mask(1);
        sel_shifted = data_reg >> 1;
        for (int g = 1; g < LG_LEVELS; g++) begin
            if (cmd.lg == LG_W'(g)) begin
                sel         = cand[g];
                sel_mask    = tkc_low_mask(1 << g);
                sel_shifted = data_reg >> (1 << g);
            end
        end
        chunk = (data_reg ^ sel.ks) & sel_mask;
    end

    always_comb
    begin
        state_next = state_reg;
        data_next  = data_reg;
        res_next   = res_reg;
        if (cmd.load_key) begin
            state_next = init_state;
        end
        else if (cmd.step) begin
            state_next = sel.state;
            data_next  = sel_shifted;
            res_next   = res_reg | (chunk << cmd.offset);
        end
        if (cmd.load_data) begin
            data_next = data_word;
            res_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            iv_low_reg   <= '0;
            iv_high_reg  <= '0;
            state_reg    <= '0;
        end
        else begin
            if (cfg_write) begin
                case (cfg_index)
                    CFG_KEY_LOW:  key_low_reg  <= cfg_data[LOW_W-1:0];
                    CFG_KEY_HIGH: key_high_reg <= cfg_data[HIGH_W-1:0];
                    CFG_IV_LOW:   iv_low_reg   <= cfg_data[LOW_W-1:0];
                    CFG_IV_HIGH:  iv_high_reg  <= cfg_data[HIGH_W-1:0];
                    default:      ;
                endcase
            end
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        res_reg  <= res_next;
        if (cmd.load_data) begin
            count_reg <= tkc_sat_count(bit_count);
        end
        if (cmd.load_out) begin
            result_word_reg  <= res_reg;
            result_count_reg <= count_reg;
        end
    end

    assign result_word  = result_word_reg;
    assign result_count = result_count_reg;

endmodule

[src/trivium_keystream_cipher.sv]
// Top level of the Trivium keystream cipher: controller plus datapath.
// Depends on tkc_pkg, tkc_ctrl and tkc_datapath.
//
// Trivium stream cipher with an 80-bit key and IV written through the cfg
// port; the user must write them only while the block is idle, which the
// block does not enforce. A transfer with mode 0 loads the state from key and
// IV and runs the 1152 warm-up steps. It returns no result and keeps the
// input stalled until the warm-up is done. A transfer with mode 1 XORs the
// low bit_count bits of data_word, bit 0 first, with the keystream. It
// returns one result with the bits above the count cleared. Counts above 64
// are clamped to 64, and a zero count gives a zero result. The step unit
// advances the state by one power of two between 1 and 64 steps per cycle.
// A data item keeps the input stalled while the controller passes its step
// state, one step per set bit of the clamped count, and its emit state, and
// longer while an earlier result still waits in the output register. The
// result then enters the output register, and the next item can be accepted
// while it waits there. The item rate is therefore bounded by that step unit.
module trivium_keystream_cipher
    import tkc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [WORD_BITS-1:0]  data_word,
    input  logic [COUNT_W-1:0]    bit_count,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [WORD_BITS-1:0]  result_word,
    output logic [COUNT_W-1:0]    result_count
);

    cmd_t cmd;

    tkc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .bit_count (bit_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    tkc_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .data_word    (data_word),
        .bit_count    (bit_count),
        .cmd          (cmd),
        .result_word  (result_word),
        .result_count (result_count)
    );

endmodule

[src/tkc_checker.sv]
// Port-level checks of the Trivium keystream cipher, bound to the top level.
// Depends on tkc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tkc_checker
    import tkc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [WORD_BITS-1:0] result_word,
    input logic [COUNT_W-1:0]   result_count
);

    // A waiting result keeps its value until it is taken.
    `TKC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(result_word) && $stable(result_count))

    // Every accepted item occupies the block for at least the next cycle.
    `TKC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    `TKC_ASSERT_IMP(a_count_range, out_valid, result_count <= COUNT_W'(WORD_BITS))

    // While out_valid is high, bits at and above the count are zero.
    `TKC_ASSERT_IMP(a_high_bits_clear, out_valid, (result_word >> result_count) == '0)

endmodule

bind trivium_keystream_cipher tkc_checker u_tkc_checker (.*);
